@@ rtl/core/drpkp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// drpkp_pkg
// Shared types and constants of the DER RSA public key parser: parse phases,
// byte classes, error codes, parser state and result records.
// ----------------------------------------------------------------------------
package drpkp_pkg;

  localparam int LenBitsDefault = 16;

  typedef enum logic [3:0] {
    PH_SEQ_TAG  = 4'd0,
    PH_SEQ_LEN  = 4'd1,
    PH_SEQ_EXT  = 4'd2,
    PH_MOD_TAG  = 4'd3,
    PH_MOD_LEN  = 4'd4,
    PH_MOD_EXT  = 4'd5,
    PH_MOD_BODY = 4'd6,
    PH_EXP_TAG  = 4'd7,
    PH_EXP_LEN  = 4'd8,
    PH_EXP_EXT  = 4'd9,
    PH_EXP_BODY = 4'd10,
    PH_DONE     = 4'd11,
    PH_FAIL     = 4'd12
  } phase_e;

  typedef enum logic [1:0] {
    CLS_FRAME = 2'd0,
    CLS_MOD   = 2'd1,
    CLS_EXP   = 2'd2,
    CLS_STRIP = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_SEQ_TAG      = 3'd1,
    ERR_MOD_TAG      = 3'd2,
    ERR_EXP_TAG      = 3'd3,
    ERR_LEN_MISMATCH = 3'd4,
    ERR_LEN_FORM     = 3'd5
  } err_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] len_acc;
    logic [1:0]  len_left;
    logic [15:0] field_left;
    logic [15:0] outer_left;
    logic        strip;
    logic [15:0] mod_cnt;
    logic [15:0] exp_cnt;
    err_e        err;
  } state_t;

  typedef struct packed {
    logic [7:0]  byte_echo;
    class_e      byte_class;
    logic [15:0] field_index;
    err_e        error_code;
    logic        parse_done;
    logic [15:0] modulus_size;
    logic [15:0] exponent_size;
  } res_t;

  localparam state_t StateReset = '{
    phase:      PH_SEQ_TAG,
    len_acc:    16'd0,
    len_left:   2'd0,
    field_left: 16'd0,
    outer_left: 16'd0,
    strip:      1'b1,
    mod_cnt:    16'd0,
    exp_cnt:    16'd0,
    err:        ERR_NONE
  };

endpackage
`default_nettype wire

@@ rtl/core/drpkp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// drpkp_if
// Valid/ready channels of the parser: input byte beats and result beats.
// ----------------------------------------------------------------------------
interface drpkp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface drpkp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_echo;
  logic [1:0]  byte_class;
  logic [15:0] field_index;
  logic [2:0]  error_code;
  logic        parse_done;
  logic [15:0] modulus_size;
  logic [15:0] exponent_size;

  modport source (
    output valid, output byte_echo, output byte_class, output field_index,
    output error_code, output parse_done, output modulus_size,
    output exponent_size, input ready
  );
  modport sink (
    input valid, input byte_echo, input byte_class, input field_index,
    input error_code, input parse_done, input modulus_size,
    input exponent_size, output ready
  );
endinterface
`default_nettype wire

@@ rtl/core/drpkp_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// drpkp_step
// One-byte update of the parser: tag and length decode, outer length
// tracking, modulus zero stripping, field indexing and error handling.
// ----------------------------------------------------------------------------
module drpkp_step #(
  parameter int LenBits = drpkp_pkg::LenBitsDefault
) (
  input  drpkp_pkg::state_t state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output drpkp_pkg::state_t state_o,
  output drpkp_pkg::res_t   res_o
);

  localparam logic [7:0] TagSeq   = 8'h30;
  localparam logic [7:0] TagInt   = 8'h02;
  localparam logic [7:0] LongForm = 8'h80;
  localparam logic [7:0] LongOne  = 8'h81;
  localparam logic [7:0] LongTwo  = 8'h82;

  function automatic drpkp_pkg::state_t fail(drpkp_pkg::state_t s, drpkp_pkg::err_e code);
    drpkp_pkg::state_t r;
    r       = s;
    r.err   = code;
    r.phase = drpkp_pkg::PH_FAIL;
    return r;
  endfunction

  function automatic drpkp_pkg::state_t finish_exp(drpkp_pkg::state_t s);
    drpkp_pkg::state_t r;
    r = s;
    if (s.outer_left == 16'd0) begin
      r.phase = drpkp_pkg::PH_DONE;
    end else begin
      r = fail(s, drpkp_pkg::ERR_LEN_MISMATCH);
    end
    return r;
  endfunction

  function automatic drpkp_pkg::state_t finish_len(drpkp_pkg::state_t s,
                                                   drpkp_pkg::phase_e lp,
                                                   logic [15:0] value);
    drpkp_pkg::state_t r;
    r = s;
    if (lp == drpkp_pkg::PH_SEQ_LEN) begin
      r.outer_left = value;
      r.phase      = drpkp_pkg::PH_MOD_TAG;
    end else if (lp == drpkp_pkg::PH_MOD_LEN) begin
      r.field_left = value;
      r.strip      = 1'b1;
      r.phase      = (value == 16'd0) ? drpkp_pkg::PH_EXP_TAG : drpkp_pkg::PH_MOD_BODY;
    end else begin
      r.field_left = value;
      if (value == 16'd0) begin
        r = finish_exp(r);
      end else begin
        r.phase = drpkp_pkg::PH_EXP_BODY;
      end
    end
    return r;
  endfunction

  function automatic drpkp_pkg::state_t first_len(drpkp_pkg::state_t s,
                                                  drpkp_pkg::phase_e lp,
                                                  drpkp_pkg::phase_e xp,
                                                  logic [7:0] b);
    drpkp_pkg::state_t r;
    r = s;
    if (b < LongForm) begin
      r = finish_len(s, lp, {8'd0, b});
    end else if (b == LongOne || b == LongTwo) begin
      r.len_acc  = 16'd0;
      r.len_left = b[1:0];
      r.phase    = xp;
    end else begin
      r = fail(s, drpkp_pkg::ERR_LEN_FORM);
    end
    return r;
  endfunction

  function automatic drpkp_pkg::state_t extra_len(drpkp_pkg::state_t s,
                                                  drpkp_pkg::phase_e lp,
                                                  logic [7:0] b);
    drpkp_pkg::state_t r;
    logic [23:0]       wide;
    r          = s;
    r.len_acc  = {s.len_acc[7:0], b};
    r.len_left = s.len_left - 2'd1;
    wide       = {8'd0, r.len_acc};
    if (r.len_left == 2'd0) begin
      if ((wide >> LenBits) != 24'd0) begin
        r = fail(r, drpkp_pkg::ERR_LEN_FORM);
      end else begin
        r = finish_len(r, lp, r.len_acc);
      end
    end
    return r;
  endfunction

  drpkp_pkg::state_t s;
  drpkp_pkg::class_e cls;
  logic [15:0]       idx;
  logic              done;

  always_comb begin
    s   = state_i;
    cls = drpkp_pkg::CLS_FRAME;
    idx = 16'd0;

    if (s.phase == drpkp_pkg::PH_DONE) begin
      s = fail(s, drpkp_pkg::ERR_LEN_MISMATCH);
    end else if (s.phase >= drpkp_pkg::PH_MOD_TAG && s.phase <= drpkp_pkg::PH_EXP_BODY) begin
      if (s.outer_left == 16'd0) begin
        s = fail(s, drpkp_pkg::ERR_LEN_MISMATCH);
      end else begin
        s.outer_left = s.outer_left - 16'd1;
      end
    end

    unique case (s.phase)
      drpkp_pkg::PH_SEQ_TAG: begin
        if (data_byte_i == TagSeq) s.phase = drpkp_pkg::PH_SEQ_LEN;
        else s = fail(s, drpkp_pkg::ERR_SEQ_TAG);
      end
      drpkp_pkg::PH_MOD_TAG: begin
        if (data_byte_i == TagInt) s.phase = drpkp_pkg::PH_MOD_LEN;
        else s = fail(s, drpkp_pkg::ERR_MOD_TAG);
      end
      drpkp_pkg::PH_EXP_TAG: begin
        if (data_byte_i == TagInt) s.phase = drpkp_pkg::PH_EXP_LEN;
        else s = fail(s, drpkp_pkg::ERR_EXP_TAG);
      end
      drpkp_pkg::PH_SEQ_LEN: begin
        s = first_len(s, drpkp_pkg::PH_SEQ_LEN, drpkp_pkg::PH_SEQ_EXT, data_byte_i);
      end
      drpkp_pkg::PH_MOD_LEN: begin
        s = first_len(s, drpkp_pkg::PH_MOD_LEN, drpkp_pkg::PH_MOD_EXT, data_byte_i);
      end
      drpkp_pkg::PH_EXP_LEN: begin
        s = first_len(s, drpkp_pkg::PH_EXP_LEN, drpkp_pkg::PH_EXP_EXT, data_byte_i);
      end
      drpkp_pkg::PH_SEQ_EXT: s = extra_len(s, drpkp_pkg::PH_SEQ_LEN, data_byte_i);
      drpkp_pkg::PH_MOD_EXT: s = extra_len(s, drpkp_pkg::PH_MOD_LEN, data_byte_i);
      drpkp_pkg::PH_EXP_EXT: s = extra_len(s, drpkp_pkg::PH_EXP_LEN, data_byte_i);
      drpkp_pkg::PH_MOD_BODY: begin
        if (s.strip && data_byte_i == 8'd0) begin
          cls = drpkp_pkg::CLS_STRIP;
        end else begin
          s.strip   = 1'b0;
          cls       = drpkp_pkg::CLS_MOD;
          idx       = s.mod_cnt;
          s.mod_cnt = s.mod_cnt + 16'd1;
        end
        s.field_left = s.field_left - 16'd1;
        if (s.field_left == 16'd0) s.phase = drpkp_pkg::PH_EXP_TAG;
      end
      drpkp_pkg::PH_EXP_BODY: begin
        cls          = drpkp_pkg::CLS_EXP;
        idx          = s.exp_cnt;
        s.exp_cnt    = s.exp_cnt + 16'd1;
        s.field_left = s.field_left - 16'd1;
        if (s.field_left == 16'd0) s = finish_exp(s);
      end
      default: ;
    endcase

    if (last_byte_i && s.phase != drpkp_pkg::PH_DONE && s.phase != drpkp_pkg::PH_FAIL) begin
      s = fail(s, drpkp_pkg::ERR_LEN_MISMATCH);
    end

    done = (s.phase == drpkp_pkg::PH_DONE);

    res_o.byte_echo     = data_byte_i;
    res_o.byte_class    = cls;
    res_o.field_index   = idx;
    res_o.error_code    = s.err;
    res_o.parse_done    = done;
    res_o.modulus_size  = done ? s.mod_cnt : 16'd0;
    res_o.exponent_size = done ? s.exp_cnt : 16'd0;

    state_o = last_byte_i ? drpkp_pkg::StateReset : s;
  end

endmodule
`default_nettype wire

@@ rtl/core/der_rsa_public_key_parser_top.sv @@
// Each accepted input beat passes the input register and the result register in turn.
// Throughput: one byte per cycle while out_o.ready does not stall; the parser
// state register is updated by a combinational step on each byte leaving the input register.
// Reset: rst_ni low clears the valid flags of both pipeline stages and returns the parser to
// expect the sequence tag; a beat flagged last_byte does the same for state.
`default_nettype none
// ----------------------------------------------------------------------------
// der_rsa_public_key_parser_top
// DER RSA public key parser: input register, per-byte parse step and result
// register with valid/ready channels on both sides.
// ----------------------------------------------------------------------------
module der_rsa_public_key_parser_top #(
  parameter int LenBits = drpkp_pkg::LenBitsDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  drpkp_in_if.sink     in_i,
  drpkp_out_if.source  out_o
);

  logic              in_vld_q;
  logic [7:0]        in_data_q;
  logic              in_last_q;
  logic              out_vld_q;
  drpkp_pkg::res_t   res_q;
  drpkp_pkg::res_t   res_d;
  drpkp_pkg::state_t state_q;
  drpkp_pkg::state_t state_d;
  logic              adv;
  logic              proc;
  logic              in_acc;

  assign adv    = !out_vld_q || out_o.ready;
  assign proc   = in_vld_q && adv;
  assign in_acc = in_i.valid && in_i.ready;

  assign in_i.ready = !in_vld_q || adv;

  drpkp_step #(
    .LenBits(LenBits)
  ) u_step (
    .state_i     (state_q),
    .data_byte_i (in_data_q),
    .last_byte_i (in_last_q),
    .state_o     (state_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= drpkp_pkg::StateReset;
    end else begin
      if (in_acc) in_vld_q <= 1'b1;
      else if (proc) in_vld_q <= 1'b0;
      if (proc) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_data_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
    if (proc) res_q <= res_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.byte_echo     = res_q.byte_echo;
  assign out_o.byte_class    = res_q.byte_class;
  assign out_o.field_index   = res_q.field_index;
  assign out_o.error_code    = res_q.error_code;
  assign out_o.parse_done    = res_q.parse_done;
  assign out_o.modulus_size  = res_q.modulus_size;
  assign out_o.exponent_size = res_q.exponent_size;

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |=> (state_q.phase == drpkp_pkg::PH_SEQ_TAG))
    else $error("parser state not cleared after last beat");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.parse_done) |-> (res_q.error_code == drpkp_pkg::ERR_NONE))
    else $error("done reported together with an error");

  a_strip_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.byte_class == drpkp_pkg::CLS_STRIP) |-> (res_q.field_index == 16'd0))
    else $error("stripped zero carries a field index");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !in_last_q && state_q.err != drpkp_pkg::ERR_NONE)
      |=> (state_q.err == $past(state_q.err)))
    else $error("sticky error changed within a blob");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_vld_q) |-> in_i.ready)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire
